// ----- hdl/mtbd_pkg.sv -----
// Shared types and constants for the bounded-draw Mersenne Twister core.
package mtbd_pkg;

	localparam int WORD_W = 32;

	typedef logic [WORD_W-1:0] word_t;

	// Twist recurrence constants.
	localparam int    TWIST_OFFSET = 397;
	localparam word_t TWIST_MATRIX = 32'h9908_b0df;
	localparam word_t HIGH_BIT     = 32'h8000_0000;
	localparam word_t LOW_BITS     = 32'h7fff_ffff;

	// Tempering masks.
	localparam word_t TEMPER_B = 32'h9d2c_5680;
	localparam word_t TEMPER_C = 32'hefc6_0000;

	// Table seeding.
	localparam word_t SEED_MULT  = 32'd69069;
	localparam word_t RESET_SEED = 32'd4357;

	// Tempering transform applied to each word as it is drawn.
	function automatic word_t temper(input word_t w);
		word_t y;
		begin
			y = w;
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & TEMPER_B);
			y = y ^ ((y << 15) & TEMPER_C);
			y = y ^ (y >> 18);
			return y;
		end
	endfunction

endpackage

// ----- hdl/mtbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module mtbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	assign rdata = rd_data_q;

endmodule

// ----- hdl/mt19937_bounded_draw_core.sv -----
// Top level of the bounded-draw MT19937 generator core.
//
// Each input transaction asks for one draw below bound; the core returns the
// tempered generator word modulo bound, or 0 for a bound of 0 (which leaves the
// generator untouched). The 624-word state lives in one RAM and is twisted one
// word at a time, just before that word is drawn, which gives the same sequence
// as twisting the whole table at once. A draw with a nonzero bound runs three
// RAM reads through the single read port, a twist and write-back state, then a
// 32-step restoring remainder loop; a zero bound goes straight to the result
// state. The first nonzero-bound draw after reset and any nonzero-bound draw
// with reseed set first fill the table from the seed register, one word per
// cycle. The seed register may be written at any time the core is idle; input
// stall is high while a draw is in progress.
module mt19937_bounded_draw_core #(
	parameter int TABLE_WORDS = 624
) (
	input  logic           clk,
	input  logic           arst_n,
	// Configuration write channel.
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  mtbd_pkg::word_t cfg_data,
	// Draw request channel.
	input  logic           in_valid,
	output logic           in_stall,
	input  mtbd_pkg::word_t bound,
	input  logic           reseed,
	// Result channel.
	output logic           out_valid,
	input  logic           out_stall,
	output mtbd_pkg::word_t value
);

	import mtbd_pkg::*;

	localparam int IDX_W = $clog2(TABLE_WORDS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_WORDS - 1);
	localparam logic [IDX_W:0]   OFFSET_W = (IDX_W+1)'(TWIST_OFFSET);
	localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W+1)'(TABLE_WORDS);

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FILL  = 3'd1;
	localparam logic [2:0] S_RD0   = 3'd2;
	localparam logic [2:0] S_RD1   = 3'd3;
	localparam logic [2:0] S_RD2   = 3'd4;
	localparam logic [2:0] S_TWIST = 3'd5;
	localparam logic [2:0] S_DIV   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             seeded_q;
	word_t            seed_q;
	word_t            fill_word_q;
	word_t            bound_q;
	word_t            cur_q;
	word_t            nxt_q;
	word_t            dvd_q;
	word_t            rem_q;
	logic [4:0]       cnt_q;
	logic             out_valid_q;
	word_t            value_q;

	logic             in_take;
	logic             out_load;
	logic [IDX_W-1:0] nxt_idx;
	logic [IDX_W:0]   far_sum;
	logic [IDX_W-1:0] far_idx;
	logic [IDX_W-1:0] ram_raddr;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	word_t            ram_wdata;
	word_t            ram_rdata;
	word_t            twist_y;
	word_t            twist_word;
	word_t            fill_prod;
	logic [32:0]      div_trial;
	logic             div_ge;
	word_t            div_rem;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Neighbor indices of the word being twisted.
	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_sum = {1'b0, idx_q} + OFFSET_W;
	assign far_idx = (far_sum >= DEPTH_W) ? IDX_W'(far_sum - DEPTH_W) : far_sum[IDX_W-1:0];

	// Read address follows the three-read sequence.
	always_comb begin
		case (state_q)
			S_RD0:   ram_raddr = idx_q;
			S_RD1:   ram_raddr = nxt_idx;
			S_RD2:   ram_raddr = far_idx;
			default: ram_raddr = idx_q;
		endcase
	end

	// Twist of one word: cur and nxt are the old words, rdata is the far word.
	assign twist_y    = (cur_q & HIGH_BIT) | (nxt_q & LOW_BITS);
	assign twist_word = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

	// Seeding multiplier, registered through fill_word_q.
	assign fill_prod = fill_word_q * SEED_MULT;

	// Table writes come from seeding or from the in-place twist.
	assign ram_we    = (state_q == S_FILL) || (state_q == S_TWIST);
	assign ram_waddr = idx_q;
	assign ram_wdata = (state_q == S_FILL) ? fill_word_q : twist_word;

	// One step of the restoring remainder.
	assign div_trial = {rem_q, dvd_q[WORD_W-1]};
	assign div_ge    = div_trial >= {1'b0, bound_q};
	assign div_rem   = div_ge ? word_t'(div_trial - {1'b0, bound_q}) : div_trial[WORD_W-1:0];

	mtbd_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_WORDS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= RESET_SEED;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (bound == '0) begin
							state_q <= S_DONE;
						end else if (reseed || !seeded_q) begin
							state_q <= S_FILL;
							idx_q   <= '0;
						end else begin
							state_q <= S_RD0;
						end
					end
				end
				S_FILL: begin
					if (idx_q == LAST_IDX) begin
						state_q  <= S_RD0;
						idx_q    <= '0;
						seeded_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_TWIST;
				S_TWIST: begin
					state_q <= S_DIV;
					idx_q   <= nxt_idx;
					cnt_q   <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the draw.
	always_ff @(posedge clk) begin
		if (in_take) begin
			bound_q     <= bound;
			fill_word_q <= seed_q;
			rem_q       <= '0;
		end
		if (state_q == S_FILL) begin
			fill_word_q <= fill_prod;
		end
		if (state_q == S_RD1) begin
			cur_q <= ram_rdata;
		end
		if (state_q == S_RD2) begin
			nxt_q <= ram_rdata;
		end
		if (state_q == S_TWIST) begin
			dvd_q <= temper(twist_word);
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			dvd_q <= dvd_q << 1;
			rem_q <= div_rem;
		end
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= rem_q;
		end
	end

	// The table is only written while seeding or twisting.
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_FILL || state_q == S_TWIST))
		else $error("table write outside seeding or twist");

	// The draw index always addresses a word of the table.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("draw index past end of table");

	// A zero bound goes straight to the result stage.
	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && bound == '0 |=> state_q == S_DONE)
		else $error("zero bound did not bypass the draw");

	// The remainder loop runs exactly 32 steps.
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == 5'd31 |=> state_q == S_DONE)
		else $error("remainder loop length wrong");

	// A fresh result lies below its nonzero bound.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && bound_q != '0 |-> value_q < bound_q)
		else $error("result not below bound");

endmodule

// ----- verif/mtbd_draw_checker.sv -----
// Scoreboard for the bounded-draw MT19937 core: predicts every draw and checks each result.
module mtbd_draw_checker #(
	parameter int TABLE_WORDS = 624,
	parameter int MAX_REPORTS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  mtbd_pkg::word_t cfg_data,
	input  logic            in_valid,
	input  logic            in_stall,
	input  mtbd_pkg::word_t bound,
	input  logic            reseed,
	input  logic            out_valid,
	input  logic            out_stall,
	input  mtbd_pkg::word_t value,
	output int              pending,
	output int              mismatches,
	output int              draws_checked
);
	import mtbd_pkg::*;

	// Shadow copy of the generator state and the seed register.
	word_t      mt_words [TABLE_WORDS];
	logic [9:0] next_pos;
	logic       words_loaded;
	word_t      seed_reg;
	word_t      value_queue [$];

	// Output scrambling applied to each drawn word.
	function automatic word_t temper_word(input word_t w);
		word_t y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		return y ^ (y >> 18);
	endfunction

	// Fill the table from the seed with the linear congruential recurrence.
	task automatic refill_words();
		mt_words[0] = seed_reg;
		for (int i = 1; i < TABLE_WORDS; i++)
			mt_words[i] = mt_words[i-1] * SEED_MULT;
		next_pos = 10'(TABLE_WORDS);
		words_loaded = 1'b1;
	endtask

	// Regenerate the whole table in one pass of the twist recurrence.
	task automatic twist_words();
		word_t y;
		for (int k = 0; k < TABLE_WORDS; k++) begin
			y = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % TABLE_WORDS] & LOW_BITS);
			mt_words[k] = mt_words[(k + TWIST_OFFSET) % TABLE_WORDS] ^ (y >> 1) ^
				(y[0] ? TWIST_MATRIX : '0);
		end
		next_pos = '0;
	endtask

	// Work out the result of one draw request and advance the shadow state.
	task automatic predict_draw(input word_t b, input logic r, output word_t v);
		if (b == '0) begin
			// A zero bound leaves the generator alone, reseed request included.
			v = '0;
		end else begin
			if (r || !words_loaded)
				refill_words();
			if (next_pos >= TABLE_WORDS)
				twist_words();
			v = temper_word(mt_words[next_pos]) % b;
			next_pos = next_pos + 1'b1;
		end
	endtask

	// Watch all three channels; results are compared before new requests are queued.
	always @(posedge clk or negedge arst_n) begin : monitor
		word_t want;
		if (!arst_n) begin
			seed_reg = RESET_SEED;
			next_pos = '0;
			words_loaded = 1'b0;
			value_queue.delete();
			mismatches = 0;
			draws_checked = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (value_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result transaction with no draw pending: value %h", value);
				end else begin
					want = value_queue.pop_front();
					draws_checked++;
					if (value !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("draw %0d: value expected %h actual %h",
								draws_checked, want, value);
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_draw(bound, reseed, want);
				value_queue.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				seed_reg = cfg_data;
			pending <= value_queue.size();
		end
	end

endmodule

// ----- verif/tb_mt19937_bounded_draw_core.sv -----
// Testbench top for the bounded-draw MT19937 core: stimulus, watchdog and verdict.
module tb_mt19937_bounded_draw_core;
	import mtbd_pkg::*;

	localparam int CLK_HALF         = 4;
	localparam int RESET_CYCLES     = 5;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_RUN_DRAWS   = 760;
	localparam int SHORT_RUN_DRAWS  = 110;
	localparam int SETTLE_CYCLES    = 60;
	localparam int CYCLE_LIMIT      = 400000;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  cfg_valid  = 1'b0;
	logic  cfg_ready;
	word_t cfg_data   = '0;
	logic  in_valid   = 1'b0;
	logic  in_stall;
	word_t bound      = '0;
	logic  reseed     = 1'b0;
	logic  out_valid;
	logic  sink_stall = 1'b0;
	logic  hold_stall = 1'b0;
	logic  out_stall;
	word_t value;

	int pending;
	int mismatches;
	int draws_checked;
	int cycle_count  = 0;
	int sent_count   = 0;
	int reseed_count = 0;
	int zero_count   = 0;
	int seed_writes  = 0;
	int tx_gap_max   = 5;
	int rx_gap_max   = 5;
	bit hold_req     = 1'b0;

	// The receiver stalls either on its own per-transaction gap or during the long hold.
	assign out_stall = sink_stall | hold_stall;

	always #CLK_HALF clk = ~clk;

	mt19937_bounded_draw_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.bound     (bound),
		.reseed    (reseed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	mtbd_draw_checker draw_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.bound         (bound),
		.reseed        (reseed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.pending       (pending),
		.mismatches    (mismatches),
		.draws_checked (draws_checked)
	);

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d draws outstanding",
				cycle_count, pending);
			$display("tb_mt19937_bounded_draw_core failed");
			$finish;
		end
	end

	// Offer one draw transaction after a random gap and hold it until accepted.
	task automatic send_draw(input word_t b, input logic r);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bound <= b;
		reseed <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		if (b == '0)
			zero_count++;
		else if (r)
			reseed_count++;
	endtask

	// Stop offering draws and wait until every predicted result has been returned.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write the seed register; only called while the core is idle.
	task automatic write_seed(input word_t s);
		cfg_valid <= 1'b1;
		cfg_data <= s;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		seed_writes++;
	endtask

	// Bounds weighted toward zero, tiny values, powers of two and the top of the range.
	function automatic word_t pick_bound();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return '0;
		else if (sel < 28)
			return $urandom_range(1, 16);
		else if (sel < 45)
			return word_t'(1) << $urandom_range(0, 31);
		else if (sel < 55)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			return $urandom;
	endfunction

	// Result side: a random stall before each transaction, then take it.
	initial begin : result_sink
		int gap;
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				sink_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			sink_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// One long receiver hold so the core backs up and stalls its input.
	initial begin : long_hold
		wait (hold_req);
		hold_stall <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		hold_stall <= 1'b0;
	end

	initial begin : stimulus
		word_t s;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero bound before the table is loaded must not seed it; the next draw seeds.
		send_draw('0, 1'b1);
		send_draw(32'd1, 1'b0);
		send_draw(32'hFFFF_FFFF, 1'b0);
		send_draw(32'h8000_0000, 1'b0);
		send_draw(32'd2, 1'b0);
		send_draw(32'd3, 1'b0);
		send_draw('0, 1'b0);
		send_draw(32'h7FFF_FFFF, 1'b0);
		send_draw(32'hFFFF_FFFE, 1'b0);
		// Reseed from the same seed restarts the sequence; a zero bound ignores reseed.
		send_draw(32'hFFFF_FFFF, 1'b1);
		send_draw('0, 1'b1);
		send_draw(32'd10, 1'b0);
		wait_drained();

		// A zero seed leaves an all-zero table, so every draw returns zero.
		write_seed('0);
		send_draw(32'hFFFF_FFFF, 1'b1);
		send_draw(32'd7, 1'b0);
		send_draw(32'hFFFF_FFFF, 1'b0);
		wait_drained();

		write_seed(32'hFFFF_FFFF);
		send_draw(32'hFFFF_FFFF, 1'b1);
		send_draw(32'd5, 1'b0);
		send_draw(32'h0000_FFFF, 1'b0);
		wait_drained();

		write_seed(32'd1);
		send_draw(32'hFFFF_FFFF, 1'b1);
		send_draw(32'd100, 1'b0);
		wait_drained();

		// Long run without reseeding so the draws cross a full table regeneration.
		write_seed($urandom);
		send_draw(32'hFFFF_FFFF, 1'b1);
		for (int i = 0; i < LONG_RUN_DRAWS; i++) begin
			if (i % 120 == 0) begin
				tx_gap_max = (((i / 120) % 3) == 1) ? 0 : 5;
				rx_gap_max = (((i / 120) % 3) == 2) ? 0 : 5;
			end
			if (i == 300) begin
				tx_gap_max = 0;
				hold_req = 1'b1;
			end
			if (i == 500)
				wait_drained();
			send_draw(pick_bound(), 1'b0);
		end

		// Shorter runs under several seeds with occasional reseeds.
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			case (p)
				0: s = 32'hFFFF_FFFF;
				2: s = '0;
				default: s = $urandom;
			endcase
			write_seed(s);
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			for (int i = 0; i < SHORT_RUN_DRAWS; i++)
				send_draw(pick_bound(), (i == 0) || ($urandom_range(0, 99) < 5));
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d draws (%0d zero bounds, %0d reseeds) over %0d seed writes",
			sent_count, zero_count, reseed_count, seed_writes);
		$display("%0d results checked, with a long run past table regeneration and a %0d-cycle hold",
			draws_checked, LONG_HOLD_CYCLES);
		if (mismatches == 0)
			$display("tb_mt19937_bounded_draw_core passed");
		else
			$display("tb_mt19937_bounded_draw_core failed");
		$finish;
	end

endmodule

// ----- mt19937_bounded_draw_core.f -----
hdl/mtbd_pkg.sv
hdl/mtbd_ram.sv
hdl/mt19937_bounded_draw_core.sv
verif/mtbd_draw_checker.sv
verif/tb_mt19937_bounded_draw_core.sv
